// File: rtl/cnv_pkg.sv
// ----------------------------------------------------------------------------
// cnv_pkg
// Shared widths, payload types and the divider cell state for the cubic
// Neville interpolator.
// ----------------------------------------------------------------------------
package cnv_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int DIFF_W     = DATA_WIDTH + 1;
    localparam int PROD_W     = 2 * DATA_WIDTH + 1;
    localparam int SUM_W      = 2 * DATA_WIDTH + 2;
    localparam int MAG_W      = 2 * DATA_WIDTH + 1;
    // Multiply, sum, magnitude, divider setup, one cell per quotient bit, clip.
    localparam int BLEND_LAT  = DATA_WIDTH + 5;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;

    typedef struct packed {
        data_t node_x0;
        data_t node_x1;
        data_t node_x2;
        data_t node_x3;
        data_t node_y0;
        data_t node_y1;
        data_t node_y2;
        data_t node_y3;
        data_t query_x;
    } in_item_t;

    typedef struct packed {
        data_t interp_value;
        logic  zero_divisor;
        logic  saturated;
    } out_item_t;

    // State handed from one divider cell to the next.
    typedef struct packed {
        logic                  ovf;
        logic                  neg;
        logic [DATA_WIDTH:0]   den;
        logic [DATA_WIDTH:0]   rem;
        logic [DATA_WIDTH-1:0] work;
    } div_state_t;

endpackage

// File: rtl/cnv_delay.sv
// ----------------------------------------------------------------------------
// cnv_delay
// Stallable shift register that keeps side data aligned with the blends.
// ----------------------------------------------------------------------------
module cnv_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             ce,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] dly_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (ce) begin
            dly_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign dout = dly_reg[DEPTH-1];

endmodule

// File: rtl/cnv_div_cell.sv
// ----------------------------------------------------------------------------
// cnv_div_cell
// One restoring division step: produces one quotient bit per item.
// ----------------------------------------------------------------------------
module cnv_div_cell (
    input  logic                   aclk,
    input  logic                   ce,
    input  cnv_pkg::div_state_t    st_in,
    output cnv_pkg::div_state_t    st_out
);

    localparam int W = cnv_pkg::DATA_WIDTH;

    cnv_pkg::div_state_t st_reg;
    cnv_pkg::div_state_t st_next;
    logic [W+1:0]        rem2;
    logic [W+1:0]        trial;
    logic                qbit;

    always_comb begin
        rem2    = {st_in.rem, st_in.work[W-1]};
        trial   = rem2 - {1'b0, st_in.den};
        qbit    = (rem2 >= {1'b0, st_in.den});
        st_next = st_in;
        st_next.rem  = qbit ? trial[W:0] : rem2[W:0];
        st_next.work = {st_in.work[W-2:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            st_reg <= st_next;
        end
    end

    assign st_out = st_reg;

endmodule

// File: rtl/cnv_blend.sv
// ----------------------------------------------------------------------------
// cnv_blend
// One Neville blend: ((q-xb)*pa + (xa-q)*pb) / (xa-xb), truncated toward
// zero and clipped to the data range, through a chain of divider cells.
// ----------------------------------------------------------------------------
module cnv_blend (
    input  logic            aclk,
    input  logic            ce,
    input  cnv_pkg::data_t  pa,
    input  cnv_pkg::data_t  pb,
    input  cnv_pkg::diff_t  da,
    input  cnv_pkg::diff_t  db,
    input  cnv_pkg::diff_t  dd,
    output cnv_pkg::data_t  res,
    output logic            sat
);

    localparam int W  = cnv_pkg::DATA_WIDTH;
    localparam int PW = cnv_pkg::PROD_W;
    localparam int SW = cnv_pkg::SUM_W;
    localparam int MW = cnv_pkg::MAG_W;

    logic signed [PW-1:0] prod_a_reg, prod_b_reg;
    cnv_pkg::diff_t       dd1_reg, dd2_reg;
    logic signed [SW-1:0] sum_reg;
    logic [MW-1:0]        num_mag_reg;
    logic                 num_neg_reg;
    logic [W:0]           den_mag_reg;
    logic                 den_neg_reg;
    cnv_pkg::div_state_t  init_next;
    cnv_pkg::div_state_t  chain [W+1];
    cnv_pkg::div_state_t  init_reg;
    cnv_pkg::data_t       res_reg, res_next;
    logic                 sat_reg, sat_next;

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_a_reg  <= PW'(da) * PW'(pa);
            prod_b_reg  <= PW'(db) * PW'(pb);
            dd1_reg     <= dd;
            sum_reg     <= SW'(prod_a_reg) + SW'(prod_b_reg);
            dd2_reg     <= dd1_reg;
            num_mag_reg <= MW'(sum_reg[SW-1] ? -sum_reg : sum_reg);
            num_neg_reg <= sum_reg[SW-1];
            den_mag_reg <= (W+1)'(dd2_reg[W] ? -dd2_reg : dd2_reg);
            den_neg_reg <= dd2_reg[W];
            init_reg    <= init_next;
            res_reg     <= res_next;
            sat_reg     <= sat_next;
        end
    end

    // A high half at or above the divisor means the quotient needs more than
    // W bits, so the cells only have to produce the low W bits.
    always_comb begin
        init_next.ovf  = (num_mag_reg[MW-1:W] >= den_mag_reg);
        init_next.neg  = num_neg_reg ^ den_neg_reg;
        init_next.den  = den_mag_reg;
        init_next.rem  = num_mag_reg[MW-1:W];
        init_next.work = num_mag_reg[W-1:0];
    end

    assign chain[0] = init_reg;

    for (genvar k = 0; k < W; k++) begin : g_cell
        cnv_div_cell u_cell (
            .aclk   (aclk),
            .ce     (ce),
            .st_in  (chain[k]),
            .st_out (chain[k+1])
        );
    end

    always_comb begin
        logic [W-1:0] quo;
        quo      = chain[W].work;
        sat_next = 1'b0;
        if (chain[W].neg) begin
            res_next = -$signed(quo);
            if (chain[W].ovf || quo > {1'b1, {(W-1){1'b0}}}) begin
                sat_next = 1'b1;
                res_next = {1'b1, {(W-1){1'b0}}};
            end
        end else begin
            res_next = $signed(quo);
            if (chain[W].ovf || quo[W-1]) begin
                sat_next = 1'b1;
                res_next = {1'b0, {(W-1){1'b1}}};
            end
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

// File: rtl/cubic_neville_interpolator.sv
// ----------------------------------------------------------------------------
// cubic_neville_interpolator
// Evaluates the cubic through four nodes at a query point by Neville's
// scheme: three linear, two quadratic and one cubic blend in a pipeline.
// ----------------------------------------------------------------------------
// Path: front difference stage, linear, quadratic and cubic blends, output register.
// Throughput: one item per cycle; each blend divides with a chain of
// DATA_WIDTH one-bit cells. The whole pipeline stalls only while the output
// register holds a result that is not taken.
// Reset clears the valid flags of every stage; data registers are not reset.
module cubic_neville_interpolator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cnv_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output cnv_pkg::out_item_t m_data
);

    localparam int W  = cnv_pkg::DATA_WIDTH;
    localparam int DW = cnv_pkg::DIFF_W;
    localparam int BL = cnv_pkg::BLEND_LAT;
    localparam int VL = 3 * BL + 2;

    function automatic cnv_pkg::diff_t dsub(cnv_pkg::data_t a, cnv_pkg::data_t b);
        dsub = DW'(a) - DW'(b);
    endfunction

    logic            ce;
    logic [VL-1:0]   vld_reg, vld_next;

    cnv_pkg::diff_t  qm1_reg, qm2_reg, qm3_reg;
    cnv_pkg::diff_t  x0q_reg, x1q_reg, x2q_reg;
    cnv_pkg::diff_t  d01_reg, d12_reg, d23_reg, d02_reg, d13_reg, d03_reg;
    cnv_pkg::data_t  y0_reg, y1_reg, y2_reg, y3_reg;
    logic            zero_reg;

    cnv_pkg::data_t  p01, p12, p23, p012, p123, p0123;
    logic            s01, s12, s23, s012, s123, s0123;
    cnv_pkg::diff_t  l2_qm2, l2_x0q, l2_d02, l2_qm3, l2_x1q, l2_d13, l2_d03;
    cnv_pkg::diff_t  l3_qm3, l3_x0q, l3_d03;
    logic            sat_l1, sat_l2, zero_d;
    cnv_pkg::out_item_t out_reg, out_next;

    assign ce      = !vld_reg[VL-1] || m_ready;
    assign s_ready = ce;

    always_comb begin
        vld_next = vld_reg;
        if (ce) begin
            vld_next = {vld_reg[VL-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Front stage: every node difference the six blends will need, the node values and the coincident-node flag.
    always_ff @(posedge aclk) begin
        if (ce) begin
            qm1_reg  <= dsub(s_data.query_x, s_data.node_x1);
            qm2_reg  <= dsub(s_data.query_x, s_data.node_x2);
            qm3_reg  <= dsub(s_data.query_x, s_data.node_x3);
            x0q_reg  <= dsub(s_data.node_x0, s_data.query_x);
            x1q_reg  <= dsub(s_data.node_x1, s_data.query_x);
            x2q_reg  <= dsub(s_data.node_x2, s_data.query_x);
            d01_reg  <= dsub(s_data.node_x0, s_data.node_x1);
            d12_reg  <= dsub(s_data.node_x1, s_data.node_x2);
            d23_reg  <= dsub(s_data.node_x2, s_data.node_x3);
            d02_reg  <= dsub(s_data.node_x0, s_data.node_x2);
            d13_reg  <= dsub(s_data.node_x1, s_data.node_x3);
            d03_reg  <= dsub(s_data.node_x0, s_data.node_x3);
            y0_reg   <= s_data.node_y0;
            y1_reg   <= s_data.node_y1;
            y2_reg   <= s_data.node_y2;
            y3_reg   <= s_data.node_y3;
            zero_reg <= (s_data.node_x0 == s_data.node_x1) ||
                        (s_data.node_x0 == s_data.node_x2) ||
                        (s_data.node_x0 == s_data.node_x3) ||
                        (s_data.node_x1 == s_data.node_x2) ||
                        (s_data.node_x1 == s_data.node_x3) ||
                        (s_data.node_x2 == s_data.node_x3);
        end
    end

    cnv_blend u_b01 (.aclk(aclk), .ce(ce), .pa(y0_reg), .pb(y1_reg), .da(qm1_reg),
                     .db(x0q_reg), .dd(d01_reg), .res(p01), .sat(s01));
    cnv_blend u_b12 (.aclk(aclk), .ce(ce), .pa(y1_reg), .pb(y2_reg), .da(qm2_reg),
                     .db(x1q_reg), .dd(d12_reg), .res(p12), .sat(s12));
    cnv_blend u_b23 (.aclk(aclk), .ce(ce), .pa(y2_reg), .pb(y3_reg), .da(qm3_reg),
                     .db(x2q_reg), .dd(d23_reg), .res(p23), .sat(s23));

    cnv_delay #(.WIDTH(7 * DW), .DEPTH(BL)) u_dly_l2 (
        .aclk (aclk),
        .ce   (ce),
        .din  ({qm2_reg, x0q_reg, d02_reg, qm3_reg, x1q_reg, d13_reg, d03_reg}),
        .dout ({l2_qm2, l2_x0q, l2_d02, l2_qm3, l2_x1q, l2_d13, l2_d03})
    );

    cnv_delay #(.WIDTH(3 * DW), .DEPTH(BL)) u_dly_l3 (
        .aclk (aclk),
        .ce   (ce),
        .din  ({l2_qm3, l2_x0q, l2_d03}),
        .dout ({l3_qm3, l3_x0q, l3_d03})
    );

    cnv_delay #(.WIDTH(1), .DEPTH(3 * BL)) u_dly_zero (
        .aclk (aclk),
        .ce   (ce),
        .din  (zero_reg),
        .dout (zero_d)
    );

    cnv_blend u_b012 (.aclk(aclk), .ce(ce), .pa(p01), .pb(p12), .da(l2_qm2),
                      .db(l2_x0q), .dd(l2_d02), .res(p012), .sat(s012));
    cnv_blend u_b123 (.aclk(aclk), .ce(ce), .pa(p12), .pb(p23), .da(l2_qm3),
                      .db(l2_x1q), .dd(l2_d13), .res(p123), .sat(s123));

    cnv_delay #(.WIDTH(1), .DEPTH(BL)) u_dly_sat1 (
        .aclk (aclk),
        .ce   (ce),
        .din  (s01 | s12 | s23),
        .dout (sat_l1)
    );

    cnv_blend u_b0123 (.aclk(aclk), .ce(ce), .pa(p012), .pb(p123), .da(l3_qm3),
                       .db(l3_x0q), .dd(l3_d03), .res(p0123), .sat(s0123));

    cnv_delay #(.WIDTH(1), .DEPTH(BL)) u_dly_sat2 (
        .aclk (aclk),
        .ce   (ce),
        .din  (sat_l1 | s012 | s123),
        .dout (sat_l2)
    );

    // Coincident nodes override whatever the blends produced.
    always_comb begin
        out_next.interp_value = zero_d ? '0 : p0123;
        out_next.zero_divisor = zero_d;
        out_next.saturated    = !zero_d && (sat_l2 || s0123);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = vld_reg[VL-1];
    assign m_data  = out_reg;

endmodule

// File: sim/cnv_checker.sv
// ----------------------------------------------------------------------------
// cnv_checker
// Watches both channels of the cubic Neville interpolator. For each item it
// takes in, it works out the expected result and keeps it in a queue. Each
// result the block hands out is compared, field by field, with the oldest
// expected result.
// ----------------------------------------------------------------------------
module cnv_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  cnv_pkg::in_item_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  cnv_pkg::out_item_t m_data,
    output int                 mismatch_count,
    output int                 pending_count,
    output int                 result_count,
    output int                 zero_div_count,
    output int                 sat_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_WIDTH = cnv_pkg::DATA_WIDTH;

    typedef cnv_pkg::data_t     data_t;
    typedef cnv_pkg::in_item_t  in_item_t;
    typedef cnv_pkg::out_item_t out_item_t;

    typedef logic signed [127:0] wide_t;

    localparam wide_t VAL_MAX = (wide_t'(1) <<< (DATA_WIDTH - 1)) - 1;
    localparam wide_t VAL_MIN = -(wide_t'(1) <<< (DATA_WIDTH - 1));

    out_item_t interp_queue[$];

    // One Neville step; the quotient truncates toward zero and is clipped.
    function automatic wide_t neville_blend(wide_t pa, wide_t pb, wide_t xa, wide_t xb,
                                            wide_t q, inout logic clipped);
        wide_t num;
        wide_t quo;
        num = (q - xb) * pa + (xa - q) * pb;
        quo = num / (xa - xb);
        if (quo > VAL_MAX) begin
            clipped = 1'b1;
            quo = VAL_MAX;
        end else if (quo < VAL_MIN) begin
            clipped = 1'b1;
            quo = VAL_MIN;
        end
        return quo;
    endfunction

    function automatic out_item_t interpolate(in_item_t it);
        out_item_t r;
        wide_t x0, x1, x2, x3, y0, y1, y2, y3, q;
        wide_t p01, p12, p23, p012, p123, p0123;
        logic clipped;
        r = '0;
        clipped = 1'b0;
        if (it.node_x0 == it.node_x1 || it.node_x0 == it.node_x2 ||
            it.node_x0 == it.node_x3 || it.node_x1 == it.node_x2 ||
            it.node_x1 == it.node_x3 || it.node_x2 == it.node_x3) begin
            r.zero_divisor = 1'b1;
            return r;
        end
        x0 = it.node_x0; x1 = it.node_x1; x2 = it.node_x2; x3 = it.node_x3;
        y0 = it.node_y0; y1 = it.node_y1; y2 = it.node_y2; y3 = it.node_y3;
        q  = it.query_x;
        p01   = neville_blend(y0, y1, x0, x1, q, clipped);
        p12   = neville_blend(y1, y2, x1, x2, q, clipped);
        p23   = neville_blend(y2, y3, x2, x3, q, clipped);
        p012  = neville_blend(p01, p12, x0, x2, q, clipped);
        p123  = neville_blend(p12, p23, x1, x3, q, clipped);
        p0123 = neville_blend(p012, p123, x0, x3, q, clipped);
        r.interp_value = data_t'(p0123);
        r.saturated    = clipped;
        return r;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            interp_queue.delete();
            mismatch_count <= 0;
            result_count   <= 0;
            zero_div_count <= 0;
            sat_count      <= 0;
        end else begin
            if (s_valid && s_ready)
                interp_queue.push_back(interpolate(s_data));
            if (m_valid && m_ready) begin
                result_count <= result_count + 1;
                if (m_data.zero_divisor) zero_div_count <= zero_div_count + 1;
                if (m_data.saturated) sat_count <= sat_count + 1;
                if (interp_queue.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: result with nothing expected: value %0d zd %0b sat %0b",
                                 $realtime, m_data.interp_value, m_data.zero_divisor,
                                 m_data.saturated);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = interp_queue.pop_front();
                    if (want.interp_value !== m_data.interp_value ||
                        want.zero_divisor !== m_data.zero_divisor ||
                        want.saturated !== m_data.saturated) begin
                        if (mismatch_count < 10)
                            $display("%0t: mismatch: value %0d/%0d zd %0b/%0b sat %0b/%0b %s",
                                     $realtime, want.interp_value, m_data.interp_value,
                                     want.zero_divisor, m_data.zero_divisor,
                                     want.saturated, m_data.saturated, "(expected/actual)");
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
        pending_count <= interp_queue.size();
    end

    initial begin
        mismatch_count = 0;
        pending_count  = 0;
        result_count   = 0;
        zero_div_count = 0;
        sat_count      = 0;
    end

endmodule

// File: sim/cubic_neville_interpolator_tb.sv
// ----------------------------------------------------------------------------
// cubic_neville_interpolator_tb
// Drives interpolation items into the block under several idle and stall
// patterns, with a long output hold-off and a full drain, and lets the
// checker compare every result against its own prediction.
// ----------------------------------------------------------------------------
module cubic_neville_interpolator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_WIDTH   = cnv_pkg::DATA_WIDTH;
    localparam int RANDOM_ITEMS = 900;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PIPE_DEPTH   = 3 * cnv_pkg::BLEND_LAT + 2;
    localparam int ONE          = 32'h0001_0000;

    typedef cnv_pkg::data_t     data_t;
    typedef cnv_pkg::in_item_t  in_item_t;
    typedef cnv_pkg::out_item_t out_item_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;

    int mismatch_count, pending_count, result_count, zero_div_count, sat_count;
    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;
    int item_count;
    logic hold_off_req;

    cubic_neville_interpolator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    cnv_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .mismatch_count(mismatch_count), .pending_count(pending_count),
        .result_count(result_count), .zero_div_count(zero_div_count),
        .sat_count(sat_count)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(negedge aclk) begin
        if (hold_off_req) begin
            m_ready <= 1'b0;
            repeat (400) @(negedge aclk);
            hold_off_req <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        item_count++;
    endtask

    function automatic in_item_t make_item(data_t x0, data_t x1, data_t x2, data_t x3,
                                           data_t y0, data_t y1, data_t y2, data_t y3,
                                           data_t q);
        in_item_t it;
        it.node_x0 = x0; it.node_x1 = x1; it.node_x2 = x2; it.node_x3 = x3;
        it.node_y0 = y0; it.node_y1 = y1; it.node_y2 = y2; it.node_y3 = y3;
        it.query_x = q;
        return it;
    endfunction

    // Mostly evenly or loosely spaced nodes with a nearby query point; some
    // items are raw noise and some have two nodes made equal.
    function automatic in_item_t random_item();
        in_item_t it;
        int kind;
        int unsigned step;
        data_t base;
        kind = $urandom_range(99);
        it = {$urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
        if (kind < 60) begin
            step = $urandom_range(1, 1 << $urandom_range(0, 22));
            base = data_t'($urandom) >>> $urandom_range(0, 30);
            it.node_x0 = base;
            it.node_x1 = base + data_t'(step) + data_t'($urandom_range(0, step / 2));
            it.node_x2 = it.node_x1 + data_t'(step) + data_t'($urandom_range(0, step / 2));
            it.node_x3 = it.node_x2 + data_t'(step) + data_t'($urandom_range(0, step / 2));
            it.node_y0 = data_t'($urandom) >>> $urandom_range(0, 31);
            it.node_y1 = data_t'($urandom) >>> $urandom_range(0, 31);
            it.node_y2 = data_t'($urandom) >>> $urandom_range(0, 31);
            it.node_y3 = data_t'($urandom) >>> $urandom_range(0, 31);
            it.query_x = base + data_t'($urandom_range(0, 4 * step)) - data_t'(step / 2);
            if ($urandom_range(1)) begin
                it.node_x1 = it.node_x3 ^ it.node_x1;
                it.node_x3 = it.node_x3 ^ it.node_x1;
                it.node_x1 = it.node_x3 ^ it.node_x1;
            end
        end else if (kind < 85) begin
            // raw noise as drawn
        end else begin
            case ($urandom_range(5))
                0: it.node_x1 = it.node_x0;
                1: it.node_x2 = it.node_x0;
                2: it.node_x3 = it.node_x0;
                3: it.node_x2 = it.node_x1;
                4: it.node_x3 = it.node_x1;
                default: it.node_x3 = it.node_x2;
            endcase
        end
        return it;
    endfunction

    task automatic random_phase(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_item(random_item());
    endtask

    initial begin
        data_t dmax, dmin;
        dmax = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        dmin = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;
        hold_off_req = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cycle_count = 0;
        item_count = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: a known cubic, exact nodes, extrapolation, the extremes,
        // coincident nodes and clipped blends.
        send_item(make_item(0, ONE, 2*ONE, 3*ONE, 0, ONE, 8*ONE, 27*ONE, ONE + ONE/2));
        send_item(make_item(0, ONE, 2*ONE, 3*ONE, 0, ONE, 8*ONE, 27*ONE, 2*ONE));
        send_item(make_item(0, ONE, 2*ONE, 3*ONE, 5, -7, 9, -11, -10*ONE));
        send_item(make_item(3*ONE, ONE, 0, 2*ONE, -ONE, ONE, 0, 4*ONE, ONE/3));
        send_item(make_item(dmin, -1, 0, dmax, dmax, dmin, dmax, dmin, 0));
        send_item(make_item(dmin, -1, 0, dmax, dmin, dmin, dmin, dmin, dmax));
        send_item(make_item(dmin, dmin+1, dmax-1, dmax, dmax, dmax, dmax, dmax, dmin));
        send_item(make_item(0, 1, 2, 3, dmax, dmin, dmax, dmin, dmax));
        send_item(make_item(0, 1, 2, 3, dmin, dmax, dmin, dmax, dmin));
        send_item(make_item(-1, 1, 2, 3, -1, -1, -1, -1, -1));
        send_item(make_item(ONE, ONE, 2*ONE, 3*ONE, 1, 2, 3, 4, 0));
        send_item(make_item(ONE, 2*ONE, ONE, 3*ONE, 1, 2, 3, 4, 0));
        send_item(make_item(ONE, 2*ONE, 3*ONE, ONE, 1, 2, 3, 4, 0));
        send_item(make_item(0, ONE, ONE, 3*ONE, 1, 2, 3, 4, 0));
        send_item(make_item(0, ONE, 3*ONE, 3*ONE, 1, 2, 3, 4, 0));
        send_item(make_item(0, 2*ONE, ONE, 2*ONE, 1, 2, 3, 4, 0));
        send_item(make_item(dmax, dmax, dmax, dmax, dmax, dmax, dmax, dmax, dmax));
        send_item(make_item(dmin, dmin, dmin, dmin, dmin, dmin, dmin, dmin, dmin));
        send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(0, 1, 2, 3, 0, 0, 0, 0, dmax));

        random_phase(200, 0, 0);
        random_phase(150, 70, 0);
        random_phase(150, 0, 70);

        // Long output hold-off while items keep coming, so the block backs up.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(negedge aclk);
        hold_off_req <= 1'b1;
        repeat (200) send_item(random_item());

        // Pause until everything has drained.
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_count != 0 || hold_off_req) @(posedge aclk);
        repeat (PIPE_DEPTH) @(posedge aclk);

        random_phase(150, 21, 21);
        random_phase(50, 0, 0);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 20) @(posedge aclk);

        $display("Sent %0d items; %0d results came back, %0d with coincident nodes,",
                 item_count, result_count, zero_div_count);
        $display("%0d clipped, under idle, stall, back-pressure and drain phases.",
                 sat_count);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/cnv_pkg.sv
rtl/cnv_delay.sv
rtl/cnv_div_cell.sv
rtl/cnv_blend.sv
rtl/cubic_neville_interpolator.sv
sim/cnv_checker.sv
sim/cubic_neville_interpolator_tb.sv
